FILE: src/fdht_pkg.sv
// ----------------------------------------------------------------------------
// fdht_pkg
// Shared types and constants for the four-way depth-preferred hash table.
// ----------------------------------------------------------------------------
package fdht_pkg;

  // Table geometry. SETS is a power of two so that the set index is the
  // low key bits.
  localparam int SETS   = 1024;
  localparam int WAYS   = 4;
  localparam int SET_AW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_IW = (WAYS > 1) ? $clog2(WAYS) : 1;

  // Field widths
  localparam int OP_W    = 2;
  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 8;
  localparam int NODES_W = 56;
  localparam int WAY_FW  = 2;
  localparam int CNT_W   = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PROBE = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // One slot: tag is key ^ depth, zero tag means empty
  typedef struct packed {
    logic [KEY_W-1:0]   tag;
    logic [DEPTH_W-1:0] depth;
    logic [NODES_W-1:0] nodes;
  } slot_t;

  // One set, a full memory row
  typedef slot_t [WAYS-1:0] row_t;

  // Way selection results for the row just read
  typedef struct packed {
    logic               probe_hit;
    logic [WAY_FW-1:0]  probe_way;
    logic [NODES_W-1:0] probe_nodes;
    logic               store_ok;
    logic [WAY_IW-1:0]  store_idx;
    logic [WAY_FW-1:0]  store_way;
  } sel_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_SWEEP,   // clearing pass after reset
    ST_IDLE,    // waiting for a beat
    ST_LOOK,    // row data valid, compute and write back
    ST_WIPE,    // clearing pass for a clear operation
    ST_REPLY    // clear finished, deliver its result
  } state_t;

endpackage

FILE: src/fdht_if.sv
// ----------------------------------------------------------------------------
// fdht_in_if / fdht_out_if
// Valid/ready channels carrying operation beats and result beats.
// ----------------------------------------------------------------------------
interface fdht_in_if import fdht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [KEY_W-1:0]   key;
  logic [DEPTH_W-1:0] depth;
  logic [NODES_W-1:0] nodes;

  modport source (output valid, op, key, depth, nodes, input ready);
  modport sink   (input valid, op, key, depth, nodes, output ready);
endinterface

interface fdht_out_if import fdht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic [NODES_W-1:0] hit_nodes;
  logic [WAY_FW-1:0]  hit_way;
  logic               written;
  logic [WAY_FW-1:0]  write_way;
  logic [CNT_W-1:0]   write_count;

  modport source (output valid, hit, hit_nodes, hit_way, written, write_way,
                  write_count, input ready);
  modport sink   (input valid, hit, hit_nodes, hit_way, written, write_way,
                  write_count, output ready);
endinterface

FILE: src/fdht_way_sel.sv
// ----------------------------------------------------------------------------
// fdht_way_sel
// Priority way selection over one set: first probe match, first way that a
// store may replace.
// ----------------------------------------------------------------------------
module fdht_way_sel import fdht_pkg::*; (
  input  row_t               row,
  input  logic [KEY_W-1:0]   key,
  input  logic [DEPTH_W-1:0] depth,
  output sel_t               sel
);

  logic [KEY_W-1:0] depth_ext;

  assign depth_ext = {{(KEY_W-DEPTH_W){1'b0}}, depth};

  // Walk from the top way down so the lowest matching way wins
  always_comb begin
    sel = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if ((row[w].tag ^ depth_ext) == key) begin
        sel.probe_hit   = 1'b1;
        sel.probe_way   = WAY_FW'(w);
        sel.probe_nodes = row[w].nodes;
      end
      if ((row[w].tag == '0) || (depth > row[w].depth)) begin
        sel.store_ok  = 1'b1;
        sel.store_idx = WAY_IW'(w);
        sel.store_way = WAY_FW'(w);
      end
    end
  end

endmodule

FILE: src/four_way_depth_preferred_hash_table_core.sv
// ----------------------------------------------------------------------------
// four_way_depth_preferred_hash_table_core
// Set-associative store of SETS sets by WAYS ways, one memory row per set.
// ----------------------------------------------------------------------------
// A probe or store reads the set's row from the single synchronous memory,
// then selects the way and, for a store that finds a way, writes the row
// back; the next beat is taken the cycle after write-back. A result waiting
// in the output register holds off write-back, and so the next input beat,
// until the output is free. A clear zeroes the memory one row per cycle,
// then delivers its result. After reset the same clearing pass runs, and no
// input beat is accepted until it ends.
// ----------------------------------------------------------------------------
module four_way_depth_preferred_hash_table_core import fdht_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  fdht_in_if.sink   in_bus,
  fdht_out_if.source out_bus
);

  // Set memory
  row_t mem [SETS];

  state_t state_r, state_nxt;

  logic [SET_AW-1:0]  sweep_r, sweep_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic [OP_W-1:0]    op_r;
  logic [KEY_W-1:0]   key_r;
  logic [DEPTH_W-1:0] depth_r;
  logic [NODES_W-1:0] nodes_r;
  row_t               rd_row_r;

  logic               out_valid_r;
  logic               hit_r, written_r;
  logic [NODES_W-1:0] hit_nodes_r;
  logic [WAY_FW-1:0]  hit_way_r, write_way_r;
  logic [CNT_W-1:0]   write_count_r;

  logic               accept, out_free, commit, sweep_last;
  logic               probe_hit, store_hit;
  logic               wr_en;
  logic [SET_AW-1:0]  wr_addr;
  row_t               wr_row;
  sel_t               sel;
  slot_t              new_slot;

  assign accept     = in_bus.valid && in_bus.ready;
  assign out_free   = !out_valid_r || out_bus.ready;
  assign sweep_last = (sweep_r == SET_AW'(SETS - 1));

  // Way selection on the row read for the current beat
  fdht_way_sel u_sel (
    .row   (rd_row_r),
    .key   (key_r),
    .depth (depth_r),
    .sel   (sel)
  );

  assign new_slot = '{tag:   key_r ^ {{(KEY_W-DEPTH_W){1'b0}}, depth_r},
                      depth: depth_r,
                      nodes: nodes_r};

  // Result flags for the beat in the look stage
  assign probe_hit = (state_r == ST_LOOK) && (op_r == OP_PROBE) && sel.probe_hit;
  assign store_hit = (state_r == ST_LOOK) && (op_r == OP_STORE) && sel.store_ok;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SWEEP: if (sweep_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) state_nxt = (in_bus.op == OP_CLEAR) ? ST_WIPE : ST_LOOK;
      end
      ST_LOOK:  if (out_free) state_nxt = ST_IDLE;
      ST_WIPE:  if (sweep_last) state_nxt = ST_REPLY;
      ST_REPLY: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_SWEEP;
    endcase
  end

  // Control outputs
  always_comb begin
    in_bus.ready = 1'b0;
    commit       = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = sweep_r;
    wr_row       = '0;
    sweep_nxt    = sweep_r;
    cnt_nxt      = cnt_r;
    case (state_r)
      ST_SWEEP, ST_WIPE: begin
        wr_en     = 1'b1;
        sweep_nxt = sweep_last ? '0 : sweep_r + 1'b1;
      end
      ST_IDLE: begin
        in_bus.ready = 1'b1;
        sweep_nxt    = '0;
        if (accept && (in_bus.op == OP_CLEAR)) cnt_nxt = '0;
      end
      ST_LOOK: begin
        commit  = out_free;
        wr_addr = key_r[SET_AW-1:0];
        wr_row  = rd_row_r;
        wr_row[sel.store_idx] = new_slot;
        if (out_free && (op_r == OP_STORE) && sel.store_ok) begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_REPLY: commit = out_free;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
      sweep_r <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Beat capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_bus.op;
      key_r   <= in_bus.key;
      depth_r <= in_bus.depth;
      nodes_r <= in_bus.nodes;
    end
  end

  // Memory read, registered
  always_ff @(posedge clk) begin
    if (accept) rd_row_r <= mem[in_bus.key[SET_AW-1:0]];
  end

  // Memory write
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_row;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Unused fields of a result beat read zero
  always_ff @(posedge clk) begin
    if (commit) begin
      hit_r         <= probe_hit;
      hit_nodes_r   <= probe_hit ? sel.probe_nodes : '0;
      hit_way_r     <= probe_hit ? sel.probe_way : '0;
      written_r     <= store_hit;
      write_way_r   <= store_hit ? sel.store_way : '0;
      write_count_r <= cnt_nxt;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.hit         = hit_r;
  assign out_bus.hit_nodes   = hit_nodes_r;
  assign out_bus.hit_way     = hit_way_r;
  assign out_bus.written     = written_r;
  assign out_bus.write_way   = write_way_r;
  assign out_bus.write_count = write_count_r;

endmodule

FILE: src/fdht_checker.sv
// ----------------------------------------------------------------------------
// fdht_checker
// Port-level checks on the hash table core, attached by bind.
// ----------------------------------------------------------------------------
module fdht_checker import fdht_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               hit,
  input logic [NODES_W-1:0] hit_nodes,
  input logic [WAY_FW-1:0]  hit_way,
  input logic               written,
  input logic [WAY_FW-1:0]  write_way,
  input logic [CNT_W-1:0]   write_count
);

  // One beat in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted back to back");

  // A result beat is never both a probe hit and a store write
  a_hit_or_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(hit && written))
    else $error("hit and written both set");

  // Miss fields read zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !hit) |-> ((hit_nodes == '0) && (hit_way == '0)))
    else $error("miss carries nonzero hit fields");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(hit) && $stable(hit_nodes)
      && $stable(hit_way) && $stable(written) && $stable(write_way)
      && $stable(write_count)))
    else $error("stalled result beat changed");

endmodule

bind four_way_depth_preferred_hash_table_core fdht_checker u_fdht_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_bus.valid),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .hit         (out_bus.hit),
  .hit_nodes   (out_bus.hit_nodes),
  .hit_way     (out_bus.hit_way),
  .written     (out_bus.written),
  .write_way   (out_bus.write_way),
  .write_count (out_bus.write_count)
);

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for four_way_depth_preferred_hash_table_core.
// ----------------------------------------------------------------------------
// A mirror of the table predicts the reply to every accepted request beat,
// and each reply beat is compared field by field with the oldest prediction.
// Probes are steered to earlier stored key and depth pairs, and stores to a
// few hot sets, so that hits, way replacement, full sets and clears all occur.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  import fdht_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SLOTS = SETS * WAYS;
  localparam int IDLE_LIMIT = 6000;
  localparam int TAIL_CYCLES = 16;
  localparam int RANDOM_BEATS = 1950;
  localparam int HISTORY_MAX = 64;

  typedef struct packed {
    logic               hit;
    logic [NODES_W-1:0] hit_nodes;
    logic [WAY_FW-1:0]  hit_way;
    logic               written;
    logic [WAY_FW-1:0]  write_way;
    logic [CNT_W-1:0]   write_count;
  } reply_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [DEPTH_W-1:0] depth;
  } entry_ref_t;

  // Mirror of the table contents plus the queue of predicted replies
  class hash_table_mirror;
    bit [KEY_W-1:0]   tags [SLOTS];
    bit [DEPTH_W-1:0] depths [SLOTS];
    bit [NODES_W-1:0] node_counts [SLOTS];
    bit [CNT_W-1:0]   store_count;
    reply_t           expected_replies[$];
    int               mismatches;

    function void wipe_table();
      foreach (tags[i]) begin
        tags[i] = '0;
        depths[i] = '0;
        node_counts[i] = '0;
      end
      store_count = '0;
    endfunction

    // Apply one accepted request and queue the reply it must produce
    function void note_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                               input logic [DEPTH_W-1:0] depth,
                               input logic [NODES_W-1:0] nodes);
      reply_t r;
      int base;
      bit found;
      r = '0;
      found = 1'b0;
      base = int'(key[SET_AW-1:0]) * WAYS;
      case (op)
        OP_PROBE: begin
          // first way whose tag, un-XORed with the probe depth, gives the key
          for (int w = 0; w < WAYS; w++) begin
            if (!found && ((tags[base+w] ^ KEY_W'(depth)) == key)) begin
              found = 1'b1;
              r.hit = 1'b1;
              r.hit_nodes = node_counts[base+w];
              r.hit_way = WAY_FW'(w);
            end
          end
        end
        OP_STORE: begin
          // first way that is empty or shallower gets replaced
          for (int w = 0; w < WAYS; w++) begin
            if (!found && (tags[base+w] == '0 || depth > depths[base+w])) begin
              found = 1'b1;
              tags[base+w] = key ^ KEY_W'(depth);
              depths[base+w] = depth;
              node_counts[base+w] = nodes;
              store_count = store_count + 1'b1;
              r.written = 1'b1;
              r.write_way = WAY_FW'(w);
            end
          end
        end
        OP_CLEAR: wipe_table();
        default: ;
      endcase
      r.write_count = store_count;
      expected_replies.push_back(r);
    endfunction

    function void check_reply(input reply_t got);
      reply_t want;
      bit bad;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: reply beat with nothing expected: hit=%0b nodes=%h way=%0d wr=%0b wway=%0d cnt=%0d",
                   $realtime, got.hit, got.hit_nodes, got.hit_way, got.written,
                   got.write_way, got.write_count);
        return;
      end
      want = expected_replies.pop_front();
      bad = (got.hit !== want.hit) || (got.hit_nodes !== want.hit_nodes) ||
            (got.hit_way !== want.hit_way) || (got.written !== want.written) ||
            (got.write_way !== want.write_way) || (got.write_count !== want.write_count);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: reply mismatch", $realtime);
          $display("  expected hit=%0b nodes=%h way=%0d wr=%0b wway=%0d cnt=%0d",
                   want.hit, want.hit_nodes, want.hit_way, want.written,
                   want.write_way, want.write_count);
          $display("  actual   hit=%0b nodes=%h way=%0d wr=%0b wway=%0d cnt=%0d",
                   got.hit, got.hit_nodes, got.hit_way, got.written,
                   got.write_way, got.write_count);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  fdht_in_if  in_bus ();
  fdht_out_if out_bus ();

  four_way_depth_preferred_hash_table_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  hash_table_mirror mirror;
  entry_ref_t       recent_stores[$];
  logic [KEY_W-SET_AW-1:0] hot_upper [4];
  logic [SET_AW-1:0]       hot_sets [8];
  int in_calm;
  int out_stall;
  int out_calm;
  int idle_cycles;

  always #1 clk = ~clk;

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [KEY_W-1:0] hot_key();
    return {hot_upper[$urandom_range(0, 3)], hot_sets[$urandom_range(0, 7)]};
  endfunction

  function automatic logic [DEPTH_W-1:0] rand_depth();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return DEPTH_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [NODES_W-1:0] rand_nodes();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return NODES_W'({$urandom(), $urandom()});
  endfunction

  // Present one request beat and hold it until the block takes it
  task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                              input logic [DEPTH_W-1:0] depth,
                              input logic [NODES_W-1:0] nodes);
    int gap;
    bit taken;
    gap = pick_gap();
    if (in_calm > 0) begin
      gap = 0;
      in_calm--;
    end else if ($urandom_range(0, 199) == 0) begin
      in_calm = $urandom_range(20, 60);
    end
    repeat (gap) begin
      @(negedge clk);
      in_bus.valid = 1'b0;
    end
    @(negedge clk);
    in_bus.valid = 1'b1;
    in_bus.op = op;
    in_bus.key = key;
    in_bus.depth = depth;
    in_bus.nodes = nodes;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      if (in_bus.ready === 1'b1) taken = 1'b1;
    end
    mirror.note_request(op, key, depth, nodes);
    if (op == OP_STORE) begin
      recent_stores.push_back('{key, depth});
      if (recent_stores.size() > HISTORY_MAX) recent_stores.delete(0);
    end
  endtask

  // Edge cases: empty-slot matches, zero tags, full sets, unused op, clear
  task automatic run_directed();
    send_request(OP_PROBE, 64'd0, 8'd0, '0);
    send_request(OP_PROBE, 64'd5, 8'd5, '0);
    send_request(OP_PROBE, 64'd5, 8'd6, '0);
    send_request(OP_STORE, '1, 8'hff, '1);
    send_request(OP_PROBE, '1, 8'hff, '0);
    send_request(OP_STORE, 64'd7, 8'd7, 56'h00_1234_5678_9abc);
    send_request(OP_STORE, 64'd7, 8'd3, 56'h55_aaaa_5555_aaaa);
    // fill one set with falling depths, then miss and replace
    send_request(OP_STORE, 64'h1111_0000_0000_0010, 8'd40, 56'd1);
    send_request(OP_STORE, 64'h2222_0000_0000_0010, 8'd30, 56'd2);
    send_request(OP_STORE, 64'h3333_0000_0000_0010, 8'd20, 56'd3);
    send_request(OP_STORE, 64'h4444_0000_0000_0010, 8'd10, 56'd4);
    send_request(OP_STORE, 64'h5555_0000_0000_0010, 8'd5, 56'd5);
    send_request(OP_STORE, 64'h6666_0000_0000_0010, 8'd25, 56'd6);
    send_request(OP_PROBE, 64'h2222_0000_0000_0010, 8'd30, '0);
    send_request(OP_PROBE, 64'h4444_0000_0000_0010, 8'd10, '0);
    send_request(OP_PROBE, 64'h4444_0000_0000_0010, 8'd11, '0);
    send_request(OP_PROBE, 64'h6666_0000_0000_0010, 8'd25, '0);
    send_request(OP_UNUSED, 64'haaaa_5555_aaaa_5555, 8'haa, 56'h55_5555_5555_5555);
    send_request(OP_STORE, 64'h8000_0000_0000_0200, 8'd0, '0);
    send_request(OP_CLEAR, 64'h0123_4567_89ab_cdef, 8'h80, '1);
    send_request(OP_PROBE, '1, 8'hff, '0);
    send_request(OP_STORE, 64'h8000_0000_0000_0000, 8'h80, 56'haa_aaaa_aaaa_aaaa);
    send_request(OP_PROBE, 64'h8000_0000_0000_0000, 8'h80, '0);
  endtask

  // Random mix aimed at a few hot sets and earlier stored pairs
  task automatic run_random(input int count);
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [DEPTH_W-1:0] depth;
    logic [NODES_W-1:0] nodes;
    entry_ref_t         pick;
    int r;
    int m;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 999);
      m = $urandom_range(0, 9);
      depth = rand_depth();
      nodes = rand_nodes();
      key = hot_key();
      pick = '0;
      if (recent_stores.size() > 0)
        pick = recent_stores[$urandom_range(0, recent_stores.size() - 1)];
      if (r < 8) begin
        op = OP_CLEAR;
      end else if (r < 25) begin
        op = OP_UNUSED;
        key = rand_key();
      end else if (r < 500) begin
        op = OP_STORE;
        if (m >= 5 && m < 7 && recent_stores.size() > 0) key = pick.key;
        else if (m == 7) key = KEY_W'(depth);
        else if (m >= 8) key = rand_key();
      end else begin
        op = OP_PROBE;
        if (m < 6 && recent_stores.size() > 0) begin
          key = pick.key;
          depth = pick.depth;
        end else if (m == 6 && recent_stores.size() > 0) begin
          key = pick.key;
        end else if (m == 7) begin
          key = KEY_W'(depth);
        end else if (m >= 8) begin
          key = rand_key();
        end
      end
      send_request(op, key, depth, nodes);
    end
  endtask

  // Reply channel back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_stall > 0) begin
        out_bus.ready = 1'b0;
        out_stall--;
      end else begin
        out_bus.ready = 1'b1;
        if (out_calm > 0) begin
          out_calm--;
        end else begin
          out_stall = pick_gap();
          if ($urandom_range(0, 199) == 0) out_calm = $urandom_range(20, 80);
        end
      end
    end
  end

  // Reply monitor
  always @(posedge clk) begin
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
      mirror.check_reply('{out_bus.hit, out_bus.hit_nodes, out_bus.hit_way,
                           out_bus.written, out_bus.write_way, out_bus.write_count});
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("four_way_depth_preferred_hash_table_core test failed");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.op = OP_PROBE;
    in_bus.key = '0;
    in_bus.depth = '0;
    in_bus.nodes = '0;
    out_bus.ready = 1'b0;
    in_calm = 0;
    out_stall = 0;
    out_calm = 0;
    idle_cycles = 0;
    mirror = new;
    foreach (hot_upper[i]) hot_upper[i] = (KEY_W-SET_AW)'({$urandom(), $urandom()});
    foreach (hot_sets[i]) hot_sets[i] = SET_AW'($urandom_range(0, SETS - 1));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    run_random(RANDOM_BEATS);
    @(negedge clk);
    in_bus.valid = 1'b0;

    // drain, then a short tail to catch stray replies
    while (mirror.expected_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mirror.mismatches == 0)
      $display("four_way_depth_preferred_hash_table_core test passed");
    else
      $display("four_way_depth_preferred_hash_table_core test failed");
    $finish;
  end

endmodule

FILE: files.f
src/fdht_pkg.sv
src/fdht_if.sv
src/fdht_way_sel.sv
src/four_way_depth_preferred_hash_table_core.sv
src/fdht_checker.sv
dv/tb.sv
